// File: sv/prcre_pkg.sv
// Package for the prefix-code repack encoder: widths, the result bundle type,
// and the code and group lookup tables. No dependencies.
package prcre_pkg;

    localparam int CharW    = 8;
    localparam int GroupW   = 5;
    localparam int LenW     = 4;
    localparam int CodeW    = 8;
    localparam int PendW    = 4;
    localparam int PendCntW = 3;
    localparam int AccW     = PendW + CodeW;
    localparam int BitCntW  = 4;
    localparam int MaxRes   = 3;
    localparam int ResCntW  = 2;

    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [CodeW-1:0] bits;
    } code_t;

    // Results of one item, oldest in slot 0.
    typedef struct packed {
        logic [ResCntW-1:0]           count;
        logic [MaxRes-1:0][CharW-1:0] chars;
        logic [MaxRes-1:0]            lasts;
    } step_res_t;

    function automatic code_t code_lookup(input logic [CharW-1:0] ch);
        code_t c;
        case (ch)
            8'h20:   c = '{len: 4'd3, bits: 8'h05};  // space
            8'h27:   c = '{len: 4'd6, bits: 8'h00};  // apostrophe
            8'h2C:   c = '{len: 4'd6, bits: 8'h03};  // comma
            8'h2D:   c = '{len: 4'd8, bits: 8'h91};  // dash
            8'h2E:   c = '{len: 4'd6, bits: 8'h11};  // period
            8'h3F:   c = '{len: 4'd6, bits: 8'h01};  // question mark
            8'h41:   c = '{len: 4'd6, bits: 8'h25};
            8'h42:   c = '{len: 4'd8, bits: 8'h9A};
            8'h43:   c = '{len: 4'd4, bits: 8'h05};
            8'h44:   c = '{len: 4'd4, bits: 8'h01};
            8'h45:   c = '{len: 4'd3, bits: 8'h06};
            8'h46:   c = '{len: 4'd5, bits: 8'h09};
            8'h47:   c = '{len: 4'd8, bits: 8'h9B};
            8'h48:   c = '{len: 4'd6, bits: 8'h10};
            8'h49:   c = '{len: 4'd4, bits: 8'h07};
            8'h4A:   c = '{len: 4'd8, bits: 8'h98};
            8'h4B:   c = '{len: 4'd4, bits: 8'h06};
            8'h4C:   c = '{len: 4'd5, bits: 8'h04};
            8'h4D:   c = '{len: 4'd8, bits: 8'h99};
            8'h4E:   c = '{len: 4'd8, bits: 8'h9E};
            8'h4F:   c = '{len: 4'd5, bits: 8'h05};
            8'h50:   c = '{len: 4'd3, bits: 8'h07};
            8'h51:   c = '{len: 4'd8, bits: 8'h9F};
            8'h52:   c = '{len: 4'd4, bits: 8'h08};
            8'h53:   c = '{len: 4'd5, bits: 8'h06};
            8'h54:   c = '{len: 4'd5, bits: 8'h07};
            8'h55:   c = '{len: 4'd8, bits: 8'h9C};
            8'h56:   c = '{len: 4'd8, bits: 8'h9D};
            8'h57:   c = '{len: 4'd6, bits: 8'h02};
            8'h58:   c = '{len: 4'd8, bits: 8'h92};
            8'h59:   c = '{len: 4'd8, bits: 8'h93};
            8'h5A:   c = '{len: 4'd8, bits: 8'h90};
            default: c = '{len: 4'd0, bits: 8'h00};  // unmapped: no bits
        endcase
        return c;
    endfunction

    function automatic logic [CharW-1:0] group_char(input logic [GroupW-1:0] g);
        logic [CharW-1:0] c;
        case (g)
            5'd26:   c = 8'h20;  // space
            5'd27:   c = 8'h2E;  // period
            5'd28:   c = 8'h2C;  // comma
            5'd29:   c = 8'h2D;  // dash
            5'd30:   c = 8'h27;  // apostrophe
            5'd31:   c = 8'h3F;  // question mark
            default: c = 8'h41 + {3'b000, g};
        endcase
        return c;
    endfunction

endpackage

// File: sv/prcre_in_if.sv
// Input channel of the prefix-code repack encoder: valid/ready plus one
// character and its end-of-line flag. Depends on prcre_pkg.
interface prcre_in_if;
    logic                        valid;
    logic                        ready;
    logic [prcre_pkg::CharW-1:0] char_in;
    logic                        end_of_line;

    modport source (output valid, output char_in, output end_of_line, input ready);
    modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

// File: sv/prcre_out_if.sv
// Output channel of the prefix-code repack encoder: valid/ready plus one
// output character and its last-of-line flag. Depends on prcre_pkg.
interface prcre_out_if;
    logic                        valid;
    logic                        ready;
    logic [prcre_pkg::CharW-1:0] char_out;
    logic                        last_of_line;

    modport source (output valid, output char_out, output last_of_line, input ready);
    modport sink   (input valid, input char_out, input last_of_line, output ready);
endinterface

// File: sv/prcre_step.sv
// Per-item datapath: code lookup, bit append, 5-bit regroup, end-of-line pad.
// Depends on prcre_pkg.
module prcre_step
(
    input  logic [prcre_pkg::CharW-1:0]    char_in,
    input  logic                           eol,
    input  logic [prcre_pkg::PendW-1:0]    pend_bits,
    input  logic [prcre_pkg::PendCntW-1:0] pend_cnt,
    output prcre_pkg::step_res_t           res,
    output logic [prcre_pkg::PendW-1:0]    pend_bits_next,
    output logic [prcre_pkg::PendCntW-1:0] pend_cnt_next
);

    prcre_pkg::code_t                    code;
    logic [prcre_pkg::AccW-1:0]          acc;
    logic [prcre_pkg::BitCntW-1:0]       n;
    logic [1:0]                          n_full;
    logic [prcre_pkg::BitCntW-1:0]       rem_wide;
    logic [prcre_pkg::PendCntW-1:0]      rem;
    logic [prcre_pkg::AccW-1:0]          sh0;
    logic [prcre_pkg::AccW-1:0]          sh1;
    logic [prcre_pkg::GroupW-1:0]        g0;
    logic [prcre_pkg::GroupW-1:0]        g1;
    logic [prcre_pkg::GroupW-1:0]        lmask;
    logic [prcre_pkg::PendW-1:0]         left;
    logic [prcre_pkg::GroupW-1:0]        gpad;
    logic                                has_pad;
    logic [prcre_pkg::ResCntW-1:0]       cnt;

    always_comb
    begin
        code = prcre_pkg::code_lookup(char_in);
        acc  = ({{prcre_pkg::CodeW{1'b0}}, pend_bits} << code.len)
             | {{prcre_pkg::PendW{1'b0}}, code.bits};
        n    = {1'b0, pend_cnt} + code.len;

        if (n >= 4'd10)
        begin
            n_full   = 2'd2;
            rem_wide = n - 4'd10;
        end
        else if (n >= 4'd5)
        begin
            n_full   = 2'd1;
            rem_wide = n - 4'd5;
        end
        else
        begin
            n_full   = 2'd0;
            rem_wide = n;
        end
        rem = rem_wide[prcre_pkg::PendCntW-1:0];

        // oldest group sits at the top of the valid bits
        sh0 = acc >> (n - 4'd5);
        sh1 = acc >> (n - 4'd10);
        g0  = sh0[prcre_pkg::GroupW-1:0];
        g1  = sh1[prcre_pkg::GroupW-1:0];

        lmask   = (5'd1 << rem) - 5'd1;
        left    = acc[prcre_pkg::PendW-1:0] & lmask[prcre_pkg::PendW-1:0];
        gpad    = {1'b0, left} << (3'd5 - rem);
        has_pad = eol && (rem != 3'd0);

        cnt = n_full + {1'b0, has_pad};

        res.count    = cnt;
        res.chars[0] = prcre_pkg::group_char((n_full != 2'd0) ? g0 : gpad);
        res.chars[1] = prcre_pkg::group_char((n_full == 2'd2) ? g1 : gpad);
        res.chars[2] = prcre_pkg::group_char(gpad);
        res.lasts[0] = eol && (cnt == 2'd1);
        res.lasts[1] = eol && (cnt == 2'd2);
        res.lasts[2] = eol && (cnt == 2'd3);

        pend_bits_next = eol ? '0 : left;
        pend_cnt_next  = eol ? '0 : rem;
    end

endmodule

// File: sv/prcre_out_queue.sv
// Result queue: holds up to three output items of one input item and
// shifts them out one per handshake. Depends on prcre_pkg, prcre_out_if.
module prcre_out_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  prcre_pkg::step_res_t res,
    output logic                 can_load,
    prcre_out_if.source          out_item
);

    logic [prcre_pkg::ResCntW-1:0]                   rem_reg;
    logic [prcre_pkg::ResCntW-1:0]                   rem_next;
    logic [prcre_pkg::MaxRes-1:0][prcre_pkg::CharW-1:0] chars_reg;
    logic [prcre_pkg::MaxRes-1:0]                    lasts_reg;
    logic                                            pop;

    assign pop      = (rem_reg != 2'd0) && out_item.ready;
    assign can_load = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop);

    assign out_item.valid        = (rem_reg != 2'd0);
    assign out_item.char_out     = chars_reg[0];
    assign out_item.last_of_line = lasts_reg[0];

    always_comb
    begin
        if (load)
            rem_next = res.count;
        else if (pop)
            rem_next = rem_reg - 2'd1;
        else
            rem_next = rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= res.chars;
            lasts_reg <= res.lasts;
        end
        else if (pop)
        begin
            chars_reg <= {8'h00, chars_reg[2], chars_reg[1]};
            lasts_reg <= {1'b0, lasts_reg[2], lasts_reg[1]};
        end
    end

`ifndef ASSERT_OFF
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 2'd3 || !pop || !load)
        else $error("queue reloaded while holding three items");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && (res.count != 2'd0) |=> out_item.valid)
        else $error("loaded results not presented");
`endif

endmodule

// File: sv/prcre_encoder_core.sv
// Top level of the prefix-code repack encoder: input register, pending-bit
// state, step datapath and result queue. Depends on prcre_pkg, the channel
// interfaces, prcre_step and prcre_out_queue.
//
//  channel   | dir | payload                         | handshake
//  ----------+-----+---------------------------------+-------------
//  in_item   | in  | char_in[7:0], end_of_line       | valid/ready
//  out_item  | out | char_out[7:0], last_of_line     | valid/ready
//
// An accepted item lands in the input register, where it is encoded; its 0 to 3
// output items load the result queue once the queue can take them, the first
// one visible in the cycle after the load. The queue sends one output item per
// cycle while out_item is ready; the queue's single output port sets the rate.
// Items with no output pass without waiting on the queue.
// rst_n clears the pending bits, the input register valid and the queue.
// A stall on out_item backs up through the queue into in_item.ready.
module prefix_code_repack_encoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    prcre_in_if.sink    in_item,
    prcre_out_if.source out_item
);

    // input register
    logic                           in_vld_reg;
    logic [prcre_pkg::CharW-1:0]    in_char_reg;
    logic                           in_eol_reg;

    // pending code bits carried between items of a line
    logic [prcre_pkg::PendW-1:0]    pend_bits_reg;
    logic [prcre_pkg::PendCntW-1:0] pend_cnt_reg;
    logic [prcre_pkg::PendW-1:0]    pend_bits_next;
    logic [prcre_pkg::PendCntW-1:0] pend_cnt_next;

    prcre_pkg::step_res_t           res;
    logic                           can_load;
    logic                           consume;
    logic                           accept;

    prcre_step u_step
    (
        .char_in        (in_char_reg),
        .eol            (in_eol_reg),
        .pend_bits      (pend_bits_reg),
        .pend_cnt       (pend_cnt_reg),
        .res            (res),
        .pend_bits_next (pend_bits_next),
        .pend_cnt_next  (pend_cnt_next)
    );

    // the held item moves on when the queue can take its results,
    // or right away when it makes none
    assign consume = in_vld_reg && ((res.count == 2'd0) || can_load);
    assign in_item.ready = !in_vld_reg || consume;
    assign accept  = in_item.valid && in_item.ready;

    prcre_out_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume && (res.count != 2'd0)),
        .res      (res),
        .can_load (can_load),
        .out_item (out_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            if (accept)
                in_vld_reg <= 1'b1;
            else if (consume)
                in_vld_reg <= 1'b0;
            if (consume)
            begin
                pend_bits_reg <= pend_bits_next;
                pend_cnt_reg  <= pend_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= in_item.char_in;
            in_eol_reg  <= in_item.end_of_line;
        end
    end

`ifndef ASSERT_OFF
    a_pend_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= 3'd4)
        else $error("pending bit count above four");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_eol_reg |=> (pend_cnt_reg == 3'd0) && (pend_bits_reg == 4'd0))
        else $error("pending state not cleared at end of line");
`endif

endmodule

// File: tb/prcre_encoder_checker.sv
`timescale 1ns / 1ps
// Checker for the prefix-code repack encoder: watches both channels, predicts
// the output characters of every accepted item and compares them in order.
// Depends on the channel interfaces prcre_in_if and prcre_out_if.
module prcre_encoder_checker
(
    input  logic clk,
    input  logic rst_n,
    prcre_in_if  in_ch,
    prcre_out_if out_ch,
    output int   errors,
    output int   pending_results,
    output int   checked_results
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    // Prefix code per character, same order as CodeChars.
    localparam string CodeChars = " ',-.?ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam int CodeLen [32] = '{3, 6, 6, 8, 6, 6,
                                    6, 8, 4, 4, 3, 5, 8, 6, 4, 8, 4, 5, 8,
                                    8, 5, 3, 8, 4, 5, 5, 8, 8, 6, 8, 8, 8};
    localparam logic [7:0] CodeBits [32] = '{8'h05, 8'h00, 8'h03, 8'h91, 8'h11, 8'h01,
                                             8'h25, 8'h9A, 8'h05, 8'h01, 8'h06, 8'h09,
                                             8'h9B, 8'h10, 8'h07, 8'h98, 8'h06, 8'h04,
                                             8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08,
                                             8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92,
                                             8'h93, 8'h90};
    localparam string GroupChars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";

    logic [3:0] held_bits;
    logic [2:0] held_count;
    out_char_t  expected_chars [$];

    function automatic logic [7:0] group_to_char(input logic [4:0] g);
        return GroupChars[g];
    endfunction

    // Append the character's code, emit every full 5-bit group, flush at end of line.
    task automatic encode_char(input logic [7:0] ch, input logic eol);
        int         len;
        int         n;
        int         emitted;
        logic [7:0] code;
        logic [11:0] acc;
        out_char_t  oc;
        len = 0;
        code = '0;
        emitted = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (CodeChars[i] == ch)
            begin
                len = CodeLen[i];
                code = CodeBits[i];
            end
        end
        acc = ({8'b0, held_bits} << len) | {4'b0, code};
        n = int'(held_count) + len;
        while (n >= 5)
        begin
            oc.ch = group_to_char(5'((acc >> (n - 5)) & 12'h1F));
            oc.last = 1'b0;
            expected_chars.push_back(oc);
            emitted++;
            n -= 5;
        end
        acc = acc & ((12'h1 << n) - 12'h1);
        if (eol)
        begin
            if (n > 0)
            begin
                oc.ch = group_to_char(5'((acc << (5 - n)) & 12'h1F));
                oc.last = 1'b1;
                expected_chars.push_back(oc);
            end
            else if (emitted > 0)
                expected_chars[expected_chars.size() - 1].last = 1'b1;
            held_bits = '0;
            held_count = '0;
        end
        else
        begin
            held_bits = acc[3:0];
            held_count = 3'(n);
        end
    endtask

    task automatic check_output(input logic [7:0] ch, input logic last);
        out_char_t exp_c;
        if (expected_chars.size() == 0)
        begin
            $error("char_out: no item expected, got %h (last_of_line %b)", ch, last);
            errors++;
        end
        else
        begin
            exp_c = expected_chars.pop_front();
            checked_results++;
            if (exp_c.ch !== ch)
            begin
                $error("char_out: expected %h, got %h", exp_c.ch, ch);
                errors++;
            end
            if (exp_c.last !== last)
            begin
                $error("last_of_line: expected %b, got %b", exp_c.last, last);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits = '0;
            held_count = '0;
            expected_chars.delete();
            errors = 0;
            checked_results = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_output(out_ch.char_out, out_ch.last_of_line);
            if (in_ch.valid && in_ch.ready)
                encode_char(in_ch.char_in, in_ch.end_of_line);
            pending_results <= expected_chars.size();
        end
    end

endmodule

// File: tb/prefix_code_repack_encoder_core_test.sv
`timescale 1ns / 1ps
// Testbench top for prefix_code_repack_encoder_core: clock, reset, line stimulus,
// random output stalls and the verdict. Depends on prcre_pkg, the channel
// interfaces, the encoder core and prcre_encoder_checker.
module prefix_code_repack_encoder_core_test;

    // no acceptance on either channel for this many cycles means a hang
    localparam int StallLimit = 2000;
    localparam int ItemGoal   = 130;
    localparam int DirCount   = 20;

    // characters that have a code; anything else adds no bits
    localparam string CodedChars = " ',-.?ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // Directed part, in order:
    //  unmapped char ending an empty line (no output at all),
    //  short code padded at end of line, exact 5-bit code ending a line,
    //  4 pending bits plus an 8-bit code giving three items,
    //  unmapped chars in mid-line, longest codes, all-zero code,
    //  end of line with groups but no leftover, unmapped bytes 0x80 and 0x7F.
    localparam logic [7:0] DirChars [DirCount] = '{8'h00, "P", "F", "C", "Z",
                                                   " ", 8'hFF, " ", "-", "'",
                                                   "a", "?", "E", "Q", "B",
                                                   "K", 8'h80, 8'h7F, ".", "D"};
    localparam logic DirEol [DirCount] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                           1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                           1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                           1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    logic clk = 1'b0;
    logic rst_n;

    // idle enables for the two sides, switched per line
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    int errors;
    int pending_results;
    int checked_results;
    int chars_sent;
    int lines_sent;
    int quiet_cycles;

    prcre_in_if  in_ch ();
    prcre_out_if out_ch ();

    prefix_code_repack_encoder_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    prcre_encoder_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .errors          (errors),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one character. valid stays high after acceptance so back-to-back
    // items never lower and raise it in the same step; a gap lowers it first.
    task automatic send_char(input logic [7:0] ch, input logic eol);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_in     <= ch;
        in_ch.end_of_line <= eol;
        do
            @(posedge clk);
        while (!in_ch.ready);
        chars_sent++;
        if (eol)
            lines_sent++;
    endtask

    // Lower valid and wait until every predicted output item has been seen.
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // Output side: random stall before each item, ready held until it moves.
    initial
    begin
        int stall;
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Watchdog: counts cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("Timeout: %0d output items still expected", pending_results);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int         line_len;
        int         mode;
        logic [7:0] ch;
        logic       eol;
        bit         coded;

        chars_sent = 0;
        lines_sent = 0;
        quiet_cycles <= 0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.char_in <= '0;
        in_ch.end_of_line <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases, with both sides idling at random
        for (int i = 0; i < DirCount; i++)
            send_char(DirChars[i], DirEol[i]);

        // sender holds off until the output side has caught up completely
        drain_outputs();

        while (chars_sent < ItemGoal)
        begin
            // pick an idle pattern for this stretch: both, one side, or none
            mode = $urandom_range(0, 3);
            src_idle  = (mode == 0) || (mode == 1);
            sink_idle = (mode == 0) || (mode == 2);
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed line: coded chars, the odd unmapped byte, ends with eol
                line_len = $urandom_range(1, 10);
                for (int i = 0; i < line_len; i++)
                begin
                    coded = ($urandom_range(0, 11) != 0);
                    ch = coded ? CodedChars[$urandom_range(0, 31)] : 8'($urandom);
                    eol = (i == line_len - 1);
                    send_char(ch, eol);
                end
            end
            else
            begin
                // noise: random bytes with random end-of-line flags
                repeat ($urandom_range(1, 6))
                begin
                    eol = ($urandom_range(0, 3) == 0);
                    send_char(8'($urandom), eol);
                end
            end
        end

        // let the last items come out with the output side unstalled
        sink_idle = 1'b0;
        drain_outputs();
        repeat (40) @(posedge clk);

        $display("Sent %0d characters in %0d lines; %0d output items compared.",
                 chars_sent, lines_sent, checked_results);
        $display("Covered corner lines, unmapped bytes, three-item steps and both-side stalls.");
        if (errors == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: prefix_code_repack_encoder_core.f
sv/prcre_pkg.sv
sv/prcre_in_if.sv
sv/prcre_out_if.sv
sv/prcre_step.sv
sv/prcre_out_queue.sv
sv/prcre_encoder_core.sv
tb/prcre_encoder_checker.sv
tb/prefix_code_repack_encoder_core_test.sv
